// File: design/bbe_pkg.sv
// Shared constants, types and the reciprocal function of the edge-aware 3x3 box blur.
`timescale 1ns / 1ps

package bbe_pkg;

  localparam int unsigned BBE_MAX_WIDTH = 1024;
  localparam int BBE_ADDR_W    = $clog2(BBE_MAX_WIDTH);
  localparam int BBE_WE_W      = $clog2(BBE_MAX_WIDTH + 1);
  localparam int BBE_CH_W      = 8;
  localparam int BBE_PIX_W     = 3 * BBE_CH_W;
  localparam int BBE_FW_W      = 11;
  localparam int BBE_FH_W      = 12;
  localparam int BBE_ROW_W     = BBE_FH_W + 1;
  localparam int BBE_COL_SUM_W = BBE_CH_W + 2;
  localparam int BBE_SUM_W     = BBE_CH_W + 4;
  localparam int BBE_NUM_W     = BBE_SUM_W + 1;
  localparam int BBE_CNT_W     = 4;
  localparam int BBE_RECIP_W   = 18;
  localparam int BBE_RECIP_SH  = 18;
  localparam int BBE_PROD_W    = BBE_NUM_W + BBE_RECIP_W;
  localparam int BBE_WIN       = 3;
  localparam int BBE_PADDR_W   = 3;

  localparam logic [BBE_FW_W-1:0] BBE_WIDTH_RST  = 11'd640;
  localparam logic [BBE_FH_W-1:0] BBE_HEIGHT_RST = 12'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_sel_t;

  typedef logic [BBE_PIX_W-1:0] pixel_t;
  // Index 0 is the top row of the window.
  typedef logic [BBE_WIN-1:0][BBE_PIX_W-1:0] column_t;
  // Index 0 is red.
  typedef logic [2:0][BBE_COL_SUM_W-1:0] col_sum_t;

  typedef struct packed {
    logic top_inc;
    logic bot_inc;
    logic left_inc;
    logic right_inc;
    logic frame_end;
  } win_mask_t;

  // ceil(2^17 / count): (2*sum + count) * recip >> 18 is the rounded mean.
  function automatic logic [BBE_RECIP_W-1:0] bbe_recip(input logic [BBE_CNT_W-1:0] cnt);
    logic [BBE_RECIP_W-1:0] m;
    unique case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: design/bbe_stream_if.sv
// Pixel and result stream interfaces of the box blur.
`timescale 1ns / 1ps

interface bbe_in_if;
  import bbe_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [BBE_CH_W-1:0] red_in;
  logic [BBE_CH_W-1:0] green_in;
  logic [BBE_CH_W-1:0] blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface bbe_out_if;
  import bbe_pkg::*;
  logic                valid;
  logic                ready;
  logic [BBE_CH_W-1:0] red_out;
  logic [BBE_CH_W-1:0] green_out;
  logic [BBE_CH_W-1:0] blue_out;
  logic                frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// File: design/bbe_cell.sv
// One window column cell: holds three pixels, shifts left, sums its included rows.
`timescale 1ns / 1ps

module bbe_cell (
  input  logic              clk,
  input  logic              shift,
  input  bbe_pkg::column_t  col_in,
  input  logic [2:0]        row_inc,
  output bbe_pkg::column_t  col_out,
  output bbe_pkg::col_sum_t col_sum
);
  import bbe_pkg::*;

  column_t col_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_sum[ch] = '0;
      for (int r = 0; r < BBE_WIN; r++) begin
        if (row_inc[r]) begin
          col_sum[ch] = col_sum[ch]
                      + BBE_COL_SUM_W'(col_q[r][BBE_PIX_W-1-BBE_CH_W*ch -: BBE_CH_W]);
        end
      end
    end
  end

endmodule

// File: design/box_blur_3x3_edge_aware.sv
// Top level: edge-aware 3x3 box blur over an RGB raster stream.
// Throughput: one item per cycle when not stalled; the row-store read/write pair and the
// 3-cell window chain each take one item per clock, with forwarding when one column
// repeats (width 1). Registers in order: stage 1, window cells, stage 3, output.
// Output k is caused by item k+width+1; the host sends width+1 drain items at frame end.
// Reset: counters and valid bits cleared, size 640x480; row stores are not cleared.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware (
  input  logic                            clk,
  input  logic                            rst,
  bbe_in_if.sink                          pixels,
  bbe_out_if.source                       blurred,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbe_pkg::BBE_PADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bbe_pkg::*;

  // Configuration
  logic [BBE_FW_W-1:0] frame_width;
  logic [BBE_FH_W-1:0] frame_height;
  logic [BBE_WE_W-1:0] w_eff;
  logic [BBE_FH_W-1:0] h_eff;
  logic                cfg_wr;
  reg_sel_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_sel_t'(paddr[BBE_PADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= BBE_WIDTH_RST;
      frame_height <= BBE_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[BBE_FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[BBE_FH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
    endcase
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = BBE_WE_W'(1);
    end else if (32'(frame_width) > BBE_MAX_WIDTH) begin
      w_eff = BBE_WE_W'(BBE_MAX_WIDTH);
    end else begin
      w_eff = BBE_WE_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? BBE_FH_W'(1) : frame_height;
  end

  // Stage enables, back to front
  logic s1_valid, s2_valid, s3_valid;
  logic en_out, en3, en2, acc;

  assign en_out       = !blurred.valid || blurred.ready;
  assign en3          = !s3_valid || en_out;
  assign en2          = !s2_valid || en3;
  assign pixels.ready = !s1_valid || en2;
  assign acc          = pixels.valid && pixels.ready;

  // Raster position
  logic [BBE_ADDR_W-1:0] col_x;
  logic [BBE_ROW_W-1:0]  row_y;
  logic [BBE_ROW_W-1:0]  h_ext;
  logic [BBE_ROW_W-1:0]  ry;
  logic                  first_col, last_col, produce;
  win_mask_t             s0_mask;
  pixel_t                pix_now;

  always_comb begin
    h_ext     = BBE_ROW_W'(h_eff);
    first_col = (col_x == '0);
    last_col  = (BBE_WE_W'(col_x) == w_eff - 1'b1);
    produce   = (row_y >= BBE_ROW_W'(2)) || ((row_y == BBE_ROW_W'(1)) && !first_col);
    ry        = first_col ? row_y - BBE_ROW_W'(2) : row_y - BBE_ROW_W'(1);
    s0_mask.top_inc   = (ry != '0);
    s0_mask.bot_inc   = (ry + BBE_ROW_W'(1)) < h_ext;
    s0_mask.left_inc  = first_col ? (w_eff != BBE_WE_W'(1)) : (col_x != BBE_ADDR_W'(1));
    s0_mask.right_inc = !first_col;
    s0_mask.frame_end = produce && first_col && (row_y == h_ext + BBE_ROW_W'(1));
    pix_now = pixels.func ? '0 : {pixels.red_in, pixels.green_in, pixels.blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_x <= '0;
      row_y <= '0;
    end else if (acc) begin
      if (s0_mask.frame_end) begin
        col_x <= '0;
        row_y <= '0;
      end else if (last_col) begin
        col_x <= '0;
        row_y <= row_y + BBE_ROW_W'(1);
      end else begin
        col_x <= col_x + BBE_ADDR_W'(1);
      end
    end
  end

  // Row stores and stage 1
  pixel_t                upper_mem  [BBE_MAX_WIDTH];
  pixel_t                middle_mem [BBE_MAX_WIDTH];
  pixel_t                rd_top, rd_mid, fwd_top, fwd_mid;
  pixel_t                s1_pix, s1_top, s1_mid;
  logic [BBE_ADDR_W-1:0] s1_addr;
  logic                  s1_fwd, s1_produce;
  win_mask_t             s1_mask;
  logic                  s1_move;

  assign s1_top  = s1_fwd ? fwd_top : rd_top;
  assign s1_mid  = s1_fwd ? fwd_mid : rd_mid;
  assign s1_move = s1_valid && en2;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_top     <= upper_mem[col_x];
      rd_mid     <= middle_mem[col_x];
      fwd_top    <= s1_mid;
      fwd_mid    <= s1_pix;
      s1_fwd     <= s1_valid && (s1_addr == col_x);
      s1_pix     <= pix_now;
      s1_addr    <= col_x;
      s1_mask    <= s0_mask;
      s1_produce <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      upper_mem[s1_addr]  <= s1_mid;
      middle_mem[s1_addr] <= s1_pix;
    end
  end

  // Window: three column cells, newest on the right
  column_t    cell_in  [BBE_WIN];
  column_t    cell_col [BBE_WIN];
  col_sum_t   cell_sum [BBE_WIN];
  win_mask_t  s2_mask;
  logic [2:0] row_inc;

  assign cell_in[BBE_WIN-1] = {s1_pix, s1_mid, s1_top};
  assign row_inc            = {s2_mask.bot_inc, 1'b1, s2_mask.top_inc};

  for (genvar i = 0; i < BBE_WIN; i++) begin : g_cell
    if (i < BBE_WIN - 1) begin : g_link
      assign cell_in[i] = cell_col[i+1];
    end
    bbe_cell u_cell (
      .clk     (clk),
      .shift   (s1_move),
      .col_in  (cell_in[i]),
      .row_inc (row_inc),
      .col_out (cell_col[i]),
      .col_sum (cell_sum[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mask <= s1_mask;
    end
  end

  // Stage 2: window sums and pixel count
  logic [2:0][BBE_SUM_W-1:0] win_sum;
  logic [1:0]                n_rows, n_cols;
  logic [BBE_CNT_W-1:0]      win_cnt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      win_sum[ch] = BBE_SUM_W'(cell_sum[1][ch])
                  + (s2_mask.left_inc  ? BBE_SUM_W'(cell_sum[0][ch]) : '0)
                  + (s2_mask.right_inc ? BBE_SUM_W'(cell_sum[2][ch]) : '0);
    end
    n_rows  = 2'd1 + {1'b0, s2_mask.top_inc} + {1'b0, s2_mask.bot_inc};
    n_cols  = 2'd1 + {1'b0, s2_mask.left_inc} + {1'b0, s2_mask.right_inc};
    win_cnt = {2'b00, n_rows} * {2'b00, n_cols};
  end

  // Stage 3: rounded mean by reciprocal multiply
  logic [2:0][BBE_SUM_W-1:0] s3_sum;
  logic [BBE_CNT_W-1:0]      s3_cnt;
  logic                      s3_fe;
  logic [BBE_RECIP_W-1:0]    recip;
  logic [BBE_NUM_W-1:0]      num  [3];
  logic [BBE_PROD_W-1:0]     prod [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum <= win_sum;
      s3_cnt <= win_cnt;
      s3_fe  <= s2_mask.frame_end;
    end
  end

  always_comb begin
    recip = bbe_recip(s3_cnt);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {s3_sum[ch], 1'b0} + BBE_NUM_W'(s3_cnt);
      prod[ch] = BBE_PROD_W'(num[ch]) * BBE_PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      blurred.red_out   <= prod[0][BBE_RECIP_SH +: BBE_CH_W];
      blurred.green_out <= prod[1][BBE_RECIP_SH +: BBE_CH_W];
      blurred.blue_out  <= prod[2][BBE_RECIP_SH +: BBE_CH_W];
      blurred.frame_end <= s3_fe;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      blurred.valid <= 1'b0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= pixels.valid;
      end
      if (en2) begin
        s2_valid <= s1_valid && s1_produce;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en_out) begin
        blurred.valid <= s3_valid;
      end
    end
  end

  // Checks
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (col_x == '0) && (row_y == '0))
    else $error("frame position not cleared after register write");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    BBE_WE_W'(col_x) < w_eff)
    else $error("column counter beyond frame width");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && s0_mask.frame_end && !cfg_wr) |=> (col_x == '0) && (row_y == '0))
    else $error("frame position not cleared after last output");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_cnt == 4'd1) || (s3_cnt == 4'd2) || (s3_cnt == 4'd3)
              || (s3_cnt == 4'd4) || (s3_cnt == 4'd6) || (s3_cnt == 4'd9))
    else $error("window pixel count has no reciprocal");

endmodule
